/* design/tfn_pkg.sv */
// ----------------------------------------------------------------------------
// tfn_pkg
// Types and fixed sizes shared by the triangle face normal core.
// ----------------------------------------------------------------------------
package tfn_pkg;

  localparam int CoordWidth     = 16;
  localparam int NormalFracBits = 14;
  localparam int NormalWidth    = NormalFracBits + 2;

  typedef struct packed {
    logic signed [CoordWidth-1:0] first_x;
    logic signed [CoordWidth-1:0] first_y;
    logic signed [CoordWidth-1:0] first_z;
    logic signed [CoordWidth-1:0] second_x;
    logic signed [CoordWidth-1:0] second_y;
    logic signed [CoordWidth-1:0] second_z;
    logic signed [CoordWidth-1:0] third_x;
    logic signed [CoordWidth-1:0] third_y;
    logic signed [CoordWidth-1:0] third_z;
  } tri_in_t;

  typedef struct packed {
    logic signed [NormalWidth-1:0] normal_x;
    logic signed [NormalWidth-1:0] normal_y;
    logic signed [NormalWidth-1:0] normal_z;
    logic                          degenerate;
  } tri_out_t;

endpackage

/* design/triangle_face_normal_core.sv */
// ----------------------------------------------------------------------------
// triangle_face_normal_core
// Unit normal of a triangle: edge cross product over its Euclidean length,
// signed Q1.14 out, truncated toward zero; zero normal and a flag when the
// cross product vanishes.
// ----------------------------------------------------------------------------
//  channel | ports                       | word
//  in      | valid_i, stall_o, in_i      | three vertices, Q8.8
//  out     | valid_o, stall_i, out_o     | normal x/y/z Q1.14, degenerate
//
//  One word per cycle while the output is not stalled. Stages, in order:
//  edges, products, cross, squares, sum, one stage per quotient bit, output.
//  The quotient bits come from a shift-add square root-free compare chain.
//  Reset clears the valid bits only. A stall on the output freezes the
//  whole pipe; stall_o follows it while a word waits at the output.
module triangle_face_normal_core
  import tfn_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     stall_o,
  input  tri_in_t  in_i,
  output logic     valid_o,
  input  logic     stall_i,
  output tri_out_t out_o
);

  localparam int CW   = CoordWidth;
  localparam int NF   = NormalFracBits;
  localparam int EW   = CW + 1;
  localparam int PW   = 2 * EW;
  localparam int MW   = 2 * CW + 1;
  localparam int SQW  = 2 * MW;
  localparam int SW   = SQW + 2;
  localparam int XW   = SW + 2 * NF + 2;
  localparam int QW   = NF + 1;
  localparam int NIT  = NF + 1;
  localparam int NSTG = NF + 7;

  logic en;
  logic [NSTG-1:0] vld_q;

  assign en      = !(vld_q[NSTG-1] && stall_i);
  assign stall_o = !en;
  assign valid_o = vld_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], valid_i};
    end
  end

  // edges
  logic signed [EW-1:0] v1_q [3];
  logic signed [EW-1:0] v2_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      v1_q[0] <= EW'(in_i.first_x)  - EW'(in_i.second_x);
      v1_q[1] <= EW'(in_i.first_y)  - EW'(in_i.second_y);
      v1_q[2] <= EW'(in_i.first_z)  - EW'(in_i.second_z);
      v2_q[0] <= EW'(in_i.second_x) - EW'(in_i.third_x);
      v2_q[1] <= EW'(in_i.second_y) - EW'(in_i.third_y);
      v2_q[2] <= EW'(in_i.second_z) - EW'(in_i.third_z);
    end
  end

  // cross product partial products
  logic signed [PW-1:0] pa_q [3];
  logic signed [PW-1:0] pb_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      pa_q[0] <= PW'(v1_q[1]) * PW'(v2_q[2]);
      pb_q[0] <= PW'(v1_q[2]) * PW'(v2_q[1]);
      pa_q[1] <= PW'(v1_q[2]) * PW'(v2_q[0]);
      pb_q[1] <= PW'(v1_q[0]) * PW'(v2_q[2]);
      pa_q[2] <= PW'(v1_q[0]) * PW'(v2_q[1]);
      pb_q[2] <= PW'(v1_q[1]) * PW'(v2_q[0]);
    end
  end

  // cross components as sign and magnitude
  logic signed [PW:0] diff [3];
  logic [PW:0]        dmag [3];
  logic [MW-1:0]      mag_q [3];
  logic [2:0]         neg_q [2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = (PW+1)'(pa_q[i]) - (PW+1)'(pb_q[i]);
      dmag[i] = diff[i][PW] ? (PW+1)'(-diff[i]) : diff[i];
    end
  end

  logic [SQW-1:0] sq_q [3];
  logic [SW-1:0]  s_q  [NIT];
  logic [XW-1:0]  r_q  [NIT][3];
  logic [XW-1:0]  p_q  [NIT][3];
  logic [QW-1:0]  qv_q [NIT+1][3];
  logic           dg_q [NIT+1];
  logic [2:0]     sg_q [NIT+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag_q[i]    <= dmag[i][MW-1:0];
        neg_q[0][i] <= diff[i][PW];
        sq_q[i]     <= SQW'(mag_q[i]) * SQW'(mag_q[i]);
      end
      neg_q[1] <= neg_q[0];
      s_q[0]   <= SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]);
      dg_q[0]  <= (sq_q[0] == '0) && (sq_q[1] == '0) && (sq_q[2] == '0);
      sg_q[0]  <= neg_q[1];
      for (int i = 0; i < 3; i++) begin
        r_q[0][i]  <= XW'(sq_q[i]) << (2 * NF);
        p_q[0][i]  <= '0;
        qv_q[0][i] <= '0;
      end
    end
  end

  // quotient bits: D = 2^(b+1)*q*S + 4^b*S is what setting bit b adds to q^2*S
  logic [XW-1:0] r_d  [NIT][3];
  logic [XW-1:0] p_d  [NIT][3];
  logic [QW-1:0] qv_d [NIT][3];
  logic [XW-1:0] dl   [NIT][3];
  logic [XW-1:0] sx   [NIT];

  always_comb begin
    for (int j = 0; j < NIT; j++) begin
      sx[j] = XW'(s_q[j]);
      for (int i = 0; i < 3; i++) begin
        dl[j][i]   = (p_q[j][i] << (NF - j + 1)) + (sx[j] << (2 * (NF - j)));
        r_d[j][i]  = r_q[j][i];
        p_d[j][i]  = p_q[j][i];
        qv_d[j][i] = qv_q[j][i];
        if (dl[j][i] <= r_q[j][i]) begin
          r_d[j][i]           = r_q[j][i] - dl[j][i];
          p_d[j][i]           = p_q[j][i] + (sx[j] << (NF - j));
          qv_d[j][i][NF - j]  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < NIT; j++) begin
        dg_q[j+1] <= dg_q[j];
        sg_q[j+1] <= sg_q[j];
        for (int i = 0; i < 3; i++) begin
          qv_q[j+1][i] <= qv_d[j][i];
        end
        // remainder and running product are spent after the last bit
        if (j < NIT - 1) begin
          s_q[j+1] <= s_q[j];
          for (int i = 0; i < 3; i++) begin
            r_q[j+1][i] <= r_d[j][i];
            p_q[j+1][i] <= p_d[j][i];
          end
        end
      end
    end
  end

  // output word
  logic [NormalWidth-1:0] nrm [3];
  tri_out_t out_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nrm[i] = NormalWidth'(qv_q[NIT][i]);
      if (dg_q[NIT]) begin
        nrm[i] = '0;
      end else if (sg_q[NIT][i]) begin
        nrm[i] = NormalWidth'(-nrm[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.normal_x   <= nrm[0];
      out_q.normal_y   <= nrm[1];
      out_q.normal_z   <= nrm[2];
      out_q.degenerate <= dg_q[NIT];
    end
  end

  assign out_o = out_q;

endmodule

/* design/tfn_checker.sv */
// ----------------------------------------------------------------------------
// tfn_checker
// Port-level checks on the triangle face normal core.
// ----------------------------------------------------------------------------
module tfn_checker
  import tfn_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     valid_i,
  input logic     stall_o,
  input tri_in_t  in_i,
  input logic     valid_o,
  input logic     stall_i,
  input tri_out_t out_o
);

  localparam logic signed [NormalWidth-1:0] One = NormalWidth'(1 << NormalFracBits);

  // a stalled word stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(out_o))
    else $error("output word changed under stall");

  // input stall only ever comes from a waiting output word
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o == (valid_o && stall_i))
    else $error("stall_o out of step with output");

  a_degen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && out_o.degenerate |->
      out_o.normal_x == '0 && out_o.normal_y == '0 && out_o.normal_z == '0)
    else $error("degenerate word with nonzero normal");

  a_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !out_o.degenerate |->
      (out_o.normal_x != '0 || out_o.normal_y != '0 || out_o.normal_z != '0) &&
      out_o.normal_x <= One && out_o.normal_x >= -One &&
      out_o.normal_y <= One && out_o.normal_y >= -One &&
      out_o.normal_z <= One && out_o.normal_z >= -One)
    else $error("normal out of unit range");

endmodule

bind triangle_face_normal_core tfn_checker u_tfn_checker (.*);
